@@ design/teq_pkg.sv @@
package teq_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int TIME_BITS  = 48;
	localparam int ID_BITS    = 4;
	localparam int PER_BITS   = 32;
	localparam int DUE_BITS   = 48;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	typedef enum logic [1:0] {
		REQ_ARM    = 2'd0,
		REQ_CANCEL = 2'd1,
		REQ_CHANGE = 2'd2,
		REQ_TICK   = 2'd3
	} req_t;

	// Command broadcast from the controller to every cell
	typedef struct packed {
		logic                 arm;
		logic                 cancel;
		logic                 change;
		logic                 expire;
		logic                 clear;
		logic [ID_BITS-1:0]   id;
		logic [PER_BITS-1:0]  ival;
		logic                 per;
		logic                 restart;
		logic [TIME_BITS-1:0] now;
	} cell_cmd_t;

	// Value handed from cell to cell along the chain: earliest armed deadline,
	// any armed slot, and the earliest due slot not yet reported this tick
	typedef struct packed {
		logic                 have;
		logic [TIME_BITS-1:0] dl;
		logic                 any;
		logic                 cand;
		logic [TIME_BITS-1:0] cdl;
		logic [ID_BITS-1:0]   cid;
	} chain_t;

	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
			input logic [PER_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {{(TIME_BITS+1-PER_BITS){1'b0}}, b};
		return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
	endfunction

endpackage

@@ design/timer_event_queue_core.sv @@
// Channel | Direction | Signals
// in      | sink      | valid/ready, req_type timer_id interval periodic start_now
// out     | source    | out_valid/out_ready, fired fired_id last pending next_due
//
// The slot cells form a registered min chain that must settle after any change;
// the controller waits in ST_SETTLE for it. A request is applied, the chain settles
// and one status beat follows; a tick expires due slots one at a time, settling after
// each, then sends one beat per fired slot. Reset clears every slot and now at once.
// A stalled output holds the controller until the beat is taken.
module timer_event_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  req_type,
	input  logic [3:0]  timer_id,
	input  logic [31:0] interval,
	input  logic        periodic,
	input  logic        start_now,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        fired,
	output logic [3:0]  fired_id,
	output logic        last,
	output logic        pending,
	output logic [47:0] next_due
);
	import teq_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_APPLY, ST_SETTLE, ST_SCAN, ST_STAT, ST_WAIT} state_t;

	state_t               state_q;
	logic [TIME_BITS-1:0] now_q;
	req_t                 req_q;
	logic [ID_BITS-1:0]   id_q;
	logic [PER_BITS-1:0]  ival_q;
	logic                 per_q, rst_q;
	logic [ID_BITS:0]     cnt_q;
	logic [ID_BITS:0]     pos_q;
	logic [ID_BITS-1:0]   settle_q;
	logic                 scan_q;
	logic [ID_BITS-1:0]   fid_q [NUM_TIMERS];
	logic                 ovalid_q;
	cell_cmd_t            cmd;
	chain_t               link [NUM_TIMERS+1];
	chain_t               fin;
	logic                 due_pick;

	assign ready = state_q == ST_IDLE;
	assign out_valid = ovalid_q;

	// Build the cell command
	always_comb begin
		cmd = '0;
		cmd.now     = now_q;
		cmd.id      = id_q;
		cmd.ival    = ival_q;
		cmd.per     = per_q;
		cmd.restart = rst_q;
		cmd.clear   = state_q == ST_IDLE;
		if (state_q == ST_APPLY) begin
			cmd.arm    = req_q == REQ_ARM;
			cmd.cancel = req_q == REQ_CANCEL;
			cmd.change = req_q == REQ_CHANGE;
		end
		if (state_q == ST_SCAN && due_pick)
			cmd.expire = 1'b1;
		if (state_q == ST_SCAN)
			cmd.id = fin.cid;
	end

	assign link[0] = '0;
	for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
		teq_cell u_cell (
			.clk(clk), .arst_n(arst_n), .idx(ID_BITS'(g)), .cmd(cmd),
			.prev(link[g]), .next(link[g+1])
		);
	end
	assign fin = link[NUM_TIMERS];
	// earliest due slot not yet reported this tick
	assign due_pick = fin.cand && cnt_q < 5'(NUM_TIMERS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			now_q    <= '0;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
			pos_q    <= '0;
			settle_q <= '0;
			scan_q   <= 1'b0;
			req_q    <= REQ_ARM;
			id_q     <= '0;
			ival_q   <= '0;
			per_q    <= 1'b0;
			rst_q    <= 1'b0;
			fired    <= 1'b0;
			fired_id <= '0;
			last     <= 1'b0;
			pending  <= 1'b0;
			next_due <= '0;
			for (int i = 0; i < NUM_TIMERS; i++)
				fid_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (valid) begin
						req_q  <= req_t'(req_type);
						id_q   <= timer_id;
						ival_q <= interval;
						per_q  <= periodic;
						rst_q  <= start_now;
						cnt_q  <= '0;
						// advance now on a tick, then let the chain settle
						if (req_t'(req_type) == REQ_TICK) begin
							now_q    <= sat_add(now_q, PER_BITS'(1));
							scan_q   <= 1'b1;
							settle_q <= ID_BITS'(NUM_TIMERS-1);
							state_q  <= ST_SETTLE;
						end else begin
							scan_q  <= 1'b0;
							state_q <= ST_APPLY;
						end
					end
				end
				ST_APPLY: begin
					settle_q <= ID_BITS'(NUM_TIMERS-1);
					state_q  <= ST_SETTLE;
				end
				ST_SETTLE: begin
					// wait until the last cell change has reached the chain end
					if (settle_q == '0) begin
						if (scan_q)
							state_q <= ST_SCAN;
						else
							state_q <= ST_STAT;
					end else begin
						settle_q <= settle_q - ID_BITS'(1);
					end
				end
				ST_SCAN: begin
					// expire the earliest due slot and note it
					if (due_pick) begin
						fid_q[cnt_q[ID_BITS-1:0]] <= fin.cid;
						cnt_q    <= cnt_q + 5'd1;
						settle_q <= ID_BITS'(NUM_TIMERS-1);
						state_q  <= ST_SETTLE;
					end else begin
						scan_q  <= 1'b0;
						state_q <= ST_STAT;
					end
				end
				ST_STAT: begin
					// status after every update, first beat
					pending  <= fin.any;
					next_due <= (fin.have && fin.dl > now_q) ? DUE_BITS'(fin.dl - now_q) : '0;
					fired    <= cnt_q != '0;
					fired_id <= (cnt_q != '0) ? fid_q[0] : '0;
					last     <= cnt_q <= 5'd1;
					pos_q    <= 5'd1;
					ovalid_q <= 1'b1;
					state_q  <= ST_WAIT;
				end
				ST_WAIT: begin
					if (ovalid_q && out_ready) begin
						if (last) begin
							ovalid_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							// advance to the next fired slot
							fired_id <= fid_q[pos_q[ID_BITS-1:0]];
							last     <= pos_q + 5'd1 == cnt_q;
							pos_q    <= pos_q + 5'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_WAIT) else $error("beat outside wait");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		ready |-> !out_valid) else $error("ready while beat pending");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 5'(NUM_TIMERS)) else $error("fire count overflow");
`endif
endmodule

@@ design/teq_cell.sv @@
module teq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [teq_pkg::ID_BITS-1:0] idx,
	input  teq_pkg::cell_cmd_t cmd,
	input  teq_pkg::chain_t   prev,
	output teq_pkg::chain_t   next
);
	import teq_pkg::*;

	logic                 valid_q;
	logic                 done_q;
	logic [TIME_BITS-1:0] dl_q;
	logic [PER_BITS-1:0]  per_q;
	logic                 rep_q;
	logic                 hit;
	logic                 due;
	logic [TIME_BITS-1:0] start;
	chain_t               link_d;
	chain_t               next_q;

	assign hit = cmd.id == idx;
	// due and not yet reported during this tick
	assign due = valid_q && !done_q && dl_q <= cmd.now;

	// start: now on restart, else the old start, clamped at zero
	always_comb begin
		if (cmd.restart)
			start = cmd.now;
		else if (dl_q >= {{(TIME_BITS-PER_BITS){1'b0}}, per_q})
			start = dl_q - {{(TIME_BITS-PER_BITS){1'b0}}, per_q};
		else
			start = '0;
	end

	// keep the earlier deadline; ties go to the lower index, which sits earlier in the chain
	always_comb begin
		link_d = prev;
		link_d.any = prev.any | valid_q;
		if (valid_q && (!prev.have || dl_q < prev.dl)) begin
			link_d.have = 1'b1;
			link_d.dl   = dl_q;
		end
		if (due && (!prev.cand || dl_q < prev.cdl)) begin
			link_d.cand = 1'b1;
			link_d.cdl  = dl_q;
			link_d.cid  = idx;
		end
	end

	assign next = next_q;

	// register the chain value before handing it to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
		end else begin
			next_q <= link_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= 1'b0;
			dl_q    <= '0;
			per_q   <= '0;
			rep_q   <= 1'b0;
		end else begin
			if (cmd.clear)
				done_q <= 1'b0;
			if (hit) begin
				if (cmd.arm) begin
					valid_q <= 1'b1;
					dl_q    <= sat_add(cmd.now, cmd.ival);
					per_q   <= cmd.ival;
					rep_q   <= cmd.per;
				end else if (cmd.cancel) begin
					valid_q <= 1'b0;
				end else if (cmd.change && valid_q && (cmd.ival != per_q || cmd.restart)) begin
					dl_q  <= sat_add(start, cmd.ival);
					per_q <= cmd.ival;
				end else if (cmd.expire) begin
					done_q <= 1'b1;
					if (rep_q)
						dl_q <= sat_add(cmd.now, per_q);
					else
						valid_q <= 1'b0;
				end
			end
		end
	end
endmodule
